// ----- rtl/ues_pkg.sv -----
// Package with the item types, codes and the pulse-width-to-centimeter conversion.
`timescale 1ns / 1ps

package ues_pkg;

    localparam int NUM_SENSORS = 4;
    localparam int SLOT_W      = $clog2(NUM_SENSORS);
    localparam int STAMP_W     = 16;
    localparam int DIST_W      = 11;

    // Divide by 58 as a multiply by ceil(2^22 / 58) and a shift; exact for 16-bit widths.
    localparam int          CM_SHIFT = 22;
    localparam int          PROD_W   = 33;
    localparam logic [16:0] CM_RECIP = 17'd72316;

    localparam logic ACTION_EDGE = 1'b0;
    localparam logic ACTION_SCAN = 1'b1;

    typedef struct packed {
        logic               action;
        logic [STAMP_W-1:0] capture_time;
    } item_t;

    typedef struct packed {
        logic              trigger_valid;
        logic [SLOT_W-1:0] trigger_sensor;
        logic [DIST_W-1:0] distance_0;
        logic [DIST_W-1:0] distance_1;
        logic [DIST_W-1:0] distance_2;
        logic [DIST_W-1:0] distance_3;
    } result_t;

    function automatic logic [DIST_W-1:0] cm_from_width(input logic [STAMP_W-1:0] width);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(width) * PROD_W'(CM_RECIP);
        return prod[CM_SHIFT +: DIST_W];
    endfunction

endpackage

// ----- rtl/ues_ranger.sv -----
// Echo capture state, slot sequencing and the published/pending distance tables.
`timescale 1ns / 1ps

module ues_ranger (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  ues_pkg::item_t  item,
    output ues_pkg::result_t result
);

    typedef enum logic [1:0] {
        PHASE_START = 2'd0,
        PHASE_END   = 2'd1,
        PHASE_DONE  = 2'd2
    } phase_t;

    phase_t                              phase_reg, phase_next;
    logic [ues_pkg::STAMP_W-1:0]         start_reg, start_next;
    logic [ues_pkg::STAMP_W-1:0]         end_reg, end_next;
    logic [ues_pkg::SLOT_W-1:0]          slot_reg, slot_next;
    logic                                first_done_reg, first_done_next;
    logic [ues_pkg::DIST_W-1:0]          pub_reg  [ues_pkg::NUM_SENSORS];
    logic [ues_pkg::DIST_W-1:0]          pub_next [ues_pkg::NUM_SENSORS];
    logic [ues_pkg::DIST_W-1:0]          pend_reg  [ues_pkg::NUM_SENSORS];
    logic [ues_pkg::DIST_W-1:0]          pend_next [ues_pkg::NUM_SENSORS];
    logic [ues_pkg::STAMP_W-1:0]         width;
    logic [ues_pkg::DIST_W-1:0]          dist_cm;
    logic                                last_slot;

    // The subtraction wraps modulo 2^16, which the conversion relies on.
    assign width     = end_reg - start_reg;
    assign dist_cm   = ues_pkg::cm_from_width(width);
    assign last_slot = (slot_reg == ues_pkg::SLOT_W'(ues_pkg::NUM_SENSORS - 1));

    always_comb
    begin
        phase_next      = phase_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        slot_next       = slot_reg;
        first_done_next = first_done_reg;
        pub_next        = pub_reg;
        pend_next       = pend_reg;
        if (step)
        begin
            if (item.action == ues_pkg::ACTION_EDGE)
            begin
                unique case (phase_reg)
                    PHASE_START:
                    begin
                        start_next = item.capture_time;
                        phase_next = PHASE_END;
                    end
                    PHASE_END:
                    begin
                        end_next   = item.capture_time;
                        phase_next = PHASE_DONE;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
            else
            begin
                if (!first_done_reg)
                begin
                    pub_next[slot_reg] = dist_cm;
                    if (last_slot)
                    begin
                        first_done_next = 1'b1;
                    end
                end
                else
                begin
                    pend_next[slot_reg] = dist_cm;
                    // The whole pending table, with the fresh last entry, goes out at once.
                    if (last_slot)
                    begin
                        pub_next = pend_next;
                    end
                end
                slot_next  = slot_reg + 1'b1;
                phase_next = PHASE_START;
            end
        end
    end

    always_comb
    begin
        result.trigger_valid  = (item.action == ues_pkg::ACTION_SCAN);
        result.trigger_sensor = (item.action == ues_pkg::ACTION_SCAN) ? slot_reg : '0;
        result.distance_0     = pub_next[0];
        result.distance_1     = pub_next[1];
        result.distance_2     = pub_next[2];
        result.distance_3     = pub_next[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PHASE_START;
            start_reg      <= '0;
            end_reg        <= '0;
            slot_reg       <= '0;
            first_done_reg <= 1'b0;
            for (int i = 0; i < ues_pkg::NUM_SENSORS; i++)
            begin
                pub_reg[i]  <= '0;
                pend_reg[i] <= '0;
            end
        end
        else
        begin
            phase_reg      <= phase_next;
            start_reg      <= start_next;
            end_reg        <= end_next;
            slot_reg       <= slot_next;
            first_done_reg <= first_done_next;
            pub_reg        <= pub_next;
            pend_reg       <= pend_next;
        end
    end

    a_scan_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.action == ues_pkg::ACTION_SCAN |=> phase_reg == PHASE_START)
        else $error("edge capture not re-armed after a scan step");

    a_slot_advances: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.action == ues_pkg::ACTION_SCAN
        |=> slot_reg == $past(slot_reg) + 1'b1)
        else $error("scan slot did not advance by one");

    a_first_scan_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(first_done_reg))
        else $error("first-scan flag cleared outside reset");

    a_edges_hold_slot: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.action == ues_pkg::ACTION_EDGE |=> $stable(slot_reg))
        else $error("edge item moved the scan slot");

endmodule

// ----- rtl/ultrasonic_echo_scanner_unit.sv -----
// An input register and a result register separate the sides of the unit.
// Throughput: one item per cycle unless result_ready holds a result, which stalls the input.
// The /58 conversion is one 16x17 multiply in the single stage between the two registers.
// Reset (rst_n, asynchronous, active low) empties both registers, re-arms edge capture,
// returns to slot 0 and clears both distance tables.
`timescale 1ns / 1ps

module ultrasonic_echo_scanner_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  ues_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output ues_pkg::result_t result
);

    logic             in_valid_reg, in_valid_next;
    ues_pkg::item_t   item_reg;
    logic             out_valid_reg, out_valid_next;
    ues_pkg::result_t result_reg;
    ues_pkg::result_t step_result;
    logic             advance;

    assign advance    = in_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (item_valid && item_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    ues_ranger u_ranger (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .result (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
        if (advance)
        begin
            result_reg <= step_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

    a_ready_means_room: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> in_valid_reg && out_valid_reg && !result_ready)
        else $error("input stalled with room downstream");

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the four-sensor ultrasonic echo scanner.
`timescale 1ns / 1ps

class ranging_scoreboard;

    typedef enum logic [1:0] {
        AWAIT_START  = 2'd0,
        AWAIT_END    = 2'd1,
        CAPTURE_DONE = 2'd2
    } capture_phase_e;

    localparam int US_PER_CM = 58;

    capture_phase_e     phase;
    logic [15:0]        echo_start;
    logic [15:0]        echo_end;
    logic [1:0]         scan_slot;
    bit                 first_scan_done;
    logic [10:0]        published[4];
    logic [10:0]        pending[4];
    ues_pkg::result_t   expected_results[$];
    int                 errors;
    int                 items_seen;
    int                 scans_seen;
    int                 results_checked;
    int                 table_publishes;

    function new();
        phase           = AWAIT_START;
        echo_start      = '0;
        echo_end        = '0;
        scan_slot       = '0;
        first_scan_done = 1'b0;
        for (int j = 0; j < 4; j++)
        begin
            published[j] = '0;
            pending[j]   = '0;
        end
        errors          = 0;
        items_seen      = 0;
        scans_seen      = 0;
        results_checked = 0;
        table_publishes = 0;
    endfunction

    // Advances the tracked scanner state by one item and queues the result it must produce.
    function void note_item(ues_pkg::item_t it);
        ues_pkg::result_t want;
        logic [15:0]      width;
        logic [10:0]      dist_cm;
        want = '0;
        items_seen++;
        if (it.action == ues_pkg::ACTION_EDGE)
        begin
            case (phase)
                AWAIT_START:
                begin
                    echo_start = it.capture_time;
                    phase      = AWAIT_END;
                end
                AWAIT_END:
                begin
                    echo_end = it.capture_time;
                    phase    = CAPTURE_DONE;
                end
                default: ;
            endcase
        end
        else
        begin
            // The pulse width wraps modulo 2^16, as in the unit, so reversed stamps give a wrapped width.
            width   = echo_end - echo_start;
            dist_cm = 11'(width / 16'(US_PER_CM));
            if (!first_scan_done)
            begin
                published[scan_slot] = dist_cm;
                if (scan_slot == 2'd3)
                    first_scan_done = 1'b1;
            end
            else
            begin
                pending[scan_slot] = dist_cm;
                if (scan_slot == 2'd3)
                begin
                    for (int j = 0; j < 4; j++)
                        published[j] = pending[j];
                    table_publishes++;
                end
            end
            want.trigger_valid  = 1'b1;
            want.trigger_sensor = scan_slot;
            scan_slot           = scan_slot + 2'd1;
            phase               = AWAIT_START;
            scans_seen++;
        end
        want.distance_0 = published[0];
        want.distance_1 = published[1];
        want.distance_2 = published[2];
        want.distance_3 = published[3];
        expected_results.push_back(want);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    function void check_result(ues_pkg::result_t got);
        ues_pkg::result_t want;
        if (expected_results.size() == 0)
        begin
            errors++;
            $display("%0t: result with none outstanding, expected nothing, actual %h",
                     $time, got);
        end
        else
        begin
            want = expected_results.pop_front();
            results_checked++;
            compare_field("trigger_valid", 16'(want.trigger_valid), 16'(got.trigger_valid));
            compare_field("trigger_sensor", 16'(want.trigger_sensor), 16'(got.trigger_sensor));
            compare_field("distance_0", 16'(want.distance_0), 16'(got.distance_0));
            compare_field("distance_1", 16'(want.distance_1), 16'(got.distance_1));
            compare_field("distance_2", 16'(want.distance_2), 16'(got.distance_2));
            compare_field("distance_3", 16'(want.distance_3), 16'(got.distance_3));
        end
    endfunction

endclass

module tb_top;

    localparam int TOTAL_ITEMS   = 1650;
    localparam int QUIET_TAIL    = 200;
    localparam int PAUSE_AT      = 800;
    localparam int STALL_LIMIT   = 500;
    localparam int DRAIN_CYCLES  = 20;

    logic             clk;
    logic             rst_n;
    logic             item_valid;
    logic             item_ready;
    ues_pkg::item_t   item;
    logic             result_valid;
    logic             result_ready;
    ues_pkg::result_t result;

    ranging_scoreboard sb;
    bit  quiet;
    int  sent_items;
    int  stall_cycles;

    ultrasonic_echo_scanner_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Both handshakes are sampled here, before any update made at this edge lands.
    always @(posedge clk)
    begin
        if (item_valid && item_ready)
            sb.note_item(item);
        if (result_valid && result_ready)
            sb.check_result(result);
        if ((item_valid && item_ready) || (result_valid && result_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic send_item(input ues_pkg::item_t it);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        sent_items++;
    endtask

    task automatic send_edge(input logic [15:0] stamp);
        ues_pkg::item_t it;
        it.action       = ues_pkg::ACTION_EDGE;
        it.capture_time = stamp;
        send_item(it);
    endtask

    task automatic send_scan();
        ues_pkg::item_t it;
        it.action       = ues_pkg::ACTION_SCAN;
        it.capture_time = 16'($urandom);
        send_item(it);
    endtask

    function automatic logic [15:0] pick_width();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(0, 1200));
            2:       return 16'(58 * $urandom_range(0, 1129) + $urandom_range(0, 2) - 1);
            default: return 16'($urandom_range(65000, 65535));
        endcase
    endfunction

    // One measurement: mostly a clean start/end/scan, sometimes broken or noisy.
    task automatic run_measurement();
        logic [15:0] start;
        int          shape;
        start = 16'($urandom);
        shape = $urandom_range(0, 9);
        if (shape <= 7 || shape == 9)
            send_edge(start);
        if (shape <= 6)
            send_edge(start + pick_width());
        if (shape == 6)
            repeat ($urandom_range(1, 3)) send_edge(16'($urandom));
        if (shape != 9)
            send_scan();
    endtask

    initial
    begin : receiver
        result_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!quiet && $urandom_range(0, 2) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            result_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    initial
    begin : watchdog
        wait (rst_n === 1'b1);
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        bit paused;
        sb           = new();
        quiet        = 1'b0;
        paused       = 1'b0;
        sent_items   = 0;
        stall_cycles = 0;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, first scan goes straight to the published table.
        send_scan();                 // nothing captured yet
        send_edge(16'h0000);
        send_edge(16'hFFFF);         // widest pulse
        send_edge(16'h1234);         // extra edge, ignored
        send_scan();
        send_edge(16'd100);
        send_edge(16'd680);          // exactly ten centimeters
        send_scan();
        send_edge(16'hFFFF);
        send_edge(16'h0000);         // reversed stamps wrap to a width of one
        send_scan();                 // slot 3 ends the first scan
        // Later scans fill the pending table until slot 3 publishes it.
        send_edge(16'd500);          // incomplete capture keeps the old end stamp
        send_scan();
        send_scan();                 // no edges at all: leftover stamps reused
        send_edge(16'd0);
        send_edge(16'd57);
        send_scan();
        send_edge(16'd0);
        send_edge(16'd58);
        send_scan();                 // publishes all four
        send_edge(16'h8000);
        send_edge(16'h7FFF);
        send_edge(16'hAAAA);
        send_edge(16'h5555);
        send_scan();
        send_scan();

        while (sent_items < TOTAL_ITEMS)
        begin
            if (sent_items >= TOTAL_ITEMS - QUIET_TAIL)
                quiet = 1'b1;
            if (!paused && sent_items >= PAUSE_AT)
            begin
                // Hold the sender until every outstanding result is back.
                paused = 1'b1;
                item_valid <= 1'b0;
                @(posedge clk);
                while (sb.expected_results.size() != 0)
                    @(posedge clk);
            end
            if ($urandom_range(0, 9) == 0)
                send_edge(16'($urandom));
            else
                run_measurement();
        end
        item_valid <= 1'b0;

        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.expected_results.size() != 0)
        begin
            sb.errors++;
            $display("%0t: %0d results never arrived", $time, sb.expected_results.size());
        end
        $display("Ran %0d items with %0d sensor scans and %0d steady-state table publishes;",
                 sb.items_seen, sb.scans_seen, sb.table_publishes);
        $display("%0d results compared, %0d mismatches.", sb.results_checked, sb.errors);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- ultrasonic_echo_scanner_unit.f -----
rtl/ues_pkg.sv
rtl/ues_ranger.sv
rtl/ultrasonic_echo_scanner_unit.sv
verif/tb_top.sv
